@@ src/llsf_pkg.sv @@
// shared types and constants for the least-squares line fit unit
// used by the controller, datapath, divider and top level

package llsf_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam logic [31:0] FIT_SCALE = 32'd1000;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CW = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    FIT_OK,
    FIT_TOO_FEW,
    FIT_DEN_ZERO,
    FIT_TOO_MANY
  } fit_status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MXX,
    S_MXY,
    S_ACC,
    S_CHECK,
    S_NSXX,
    S_SXSX,
    S_NSXY,
    S_SXSY,
    S_NUM,
    S_SCALE,
    S_DIVS,
    S_DWAIT,
    S_SLOPE,
    S_ASX,
    S_SY1K,
    S_ICN,
    S_DIVI,
    S_IWAIT,
    S_ICPT,
    S_OUT
  } fsm_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MXX,
    OP_MXY,
    OP_ACC,
    OP_NSXX,
    OP_SXSX,
    OP_NSXY,
    OP_SXSY,
    OP_NUM,
    OP_SCALE,
    OP_DIVS,
    OP_SLOPE,
    OP_ASX,
    OP_SY1K,
    OP_ICN,
    OP_DIVI,
    OP_ICPT,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic is_last;
    logic overflowed;
    logic too_few;
    logic den_zero;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

@@ src/llsf_div.sv @@
// iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero
// depends on llsf_pkg

module llsf_div import llsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [31:0]       rem;
  logic [31:0]       quo;
  logic [31:0]       dvs;
  logic              neg;
  logic [DIV_CW-1:0] cnt;

  logic [32:0] rem_sh;
  logic        ge;
  logic [31:0] diff;

  // remainder stays below the divisor, so the difference fits in 32 bits
  always_comb begin
    rem_sh = {rem, quo[31]};
    ge     = rem_sh >= {1'b0, dvs};
    diff   = rem_sh[31:0] - dvs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CW'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // magnitudes; the most negative value keeps its bit pattern
      rem <= '0;
      quo <= num[31] ? 32'd0 - num : num;
      dvs <= den[31] ? 32'd0 - den : den;
      neg <= num[31] ^ den[31];
    end else if (busy) begin
      rem <= ge ? diff : rem_sh[31:0];
      quo <= {quo[30:0], ge};
    end
  end

  assign quotient = neg ? 32'd0 - quo : quo;

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider not busy after start");
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (busy && !start && cnt == DIV_CW'(1)) |=> !busy)
    else $error("divider ran past its last step");

endmodule

@@ src/llsf_ctrl.sv @@
// sequencer for the line fit: point accumulation steps and the fit sequence
// depends on llsf_pkg; drives llsf_dp through an op code

module llsf_ctrl import llsf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_op_t     op
);

  fsm_state_t state;
  fsm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_MXX;
      S_MXX:   state_next = S_MXY;
      S_MXY:   state_next = S_ACC;
      S_ACC:   state_next = status.is_last ? S_CHECK : S_IDLE;
      S_CHECK: state_next = (status.overflowed || status.too_few) ? S_OUT : S_NSXX;
      S_NSXX:  state_next = S_SXSX;
      S_SXSX:  state_next = S_NSXY;
      S_NSXY:  state_next = S_SXSY;
      S_SXSY:  state_next = status.den_zero ? S_OUT : S_NUM;
      S_NUM:   state_next = S_SCALE;
      S_SCALE: state_next = S_DIVS;
      S_DIVS:  state_next = S_DWAIT;
      S_DWAIT: if (!status.div_busy) state_next = S_SLOPE;
      S_SLOPE: state_next = S_ASX;
      S_ASX:   state_next = S_SY1K;
      S_SY1K:  state_next = S_ICN;
      S_ICN:   state_next = S_DIVI;
      S_DIVI:  state_next = S_IWAIT;
      S_IWAIT: if (!status.div_busy) state_next = S_ICPT;
      S_ICPT:  state_next = S_OUT;
      S_OUT:   if (status.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    op       = OP_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LOAD;
      end
      S_MXX:   op = OP_MXX;
      S_MXY:   op = OP_MXY;
      S_ACC:   op = OP_ACC;
      S_NSXX:  op = OP_NSXX;
      S_SXSX:  op = OP_SXSX;
      S_NSXY:  op = OP_NSXY;
      S_SXSY:  op = OP_SXSY;
      S_NUM:   op = OP_NUM;
      S_SCALE: op = OP_SCALE;
      S_DIVS:  op = OP_DIVS;
      S_SLOPE: op = OP_SLOPE;
      S_ASX:   op = OP_ASX;
      S_SY1K:  op = OP_SY1K;
      S_ICN:   op = OP_ICN;
      S_DIVI:  op = OP_DIVI;
      S_ICPT:  op = OP_ICPT;
      S_OUT:   if (status.out_free) op = OP_OUT;
      default: op = OP_NONE;
    endcase
  end

  a_slope_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DWAIT && !status.div_busy) |=> state == S_SLOPE)
    else $error("slope step missed after division");

endmodule

@@ src/llsf_dp.sv @@
// datapath: running sums, shared 32x32 multiplier, divider and output register
// depends on llsf_pkg and llsf_div

module llsf_dp import llsf_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_op_t             op,
  output dp_status_t         status,
  input  logic               cfg_valid,
  input  logic               cfg_data,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] y_value,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] slope_scaled,
  output logic signed [31:0] intercept_scaled,
  output logic [1:0]         fit_status,
  output logic [6:0]         points_used
);

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  logic          x_from_index;
  logic [31:0]   sum_x;
  logic [31:0]   sum_y;
  logic [31:0]   sum_xx;
  logic [31:0]   sum_xy;
  logic [CW-1:0] count;
  logic          overflowed;

  logic [31:0] x_reg;
  logic [31:0] y_reg;
  logic        last_reg;
  logic        keep;
  logic [31:0] prod;
  logic [31:0] tmp;
  logic [31:0] den;
  logic [31:0] slope;
  logic [31:0] icpt;

  logic [31:0] n32;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic        mul_en;
  logic [31:0] mul_lo;

  logic        div_start;
  logic [31:0] div_num;
  logic [31:0] div_den;
  logic        div_busy;
  logic [31:0] div_q;

  fit_status_t status_next;

  assign n32 = 32'(count);

  // only the low word of each product is kept
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (op)
      OP_MXX:   begin mul_a = x_reg; mul_b = x_reg;     end
      OP_MXY:   begin mul_a = x_reg; mul_b = y_reg;     end
      OP_NSXX:  begin mul_a = n32;   mul_b = sum_xx;    end
      OP_SXSX:  begin mul_a = sum_x; mul_b = sum_x;     end
      OP_NSXY:  begin mul_a = n32;   mul_b = sum_xy;    end
      OP_SXSY:  begin mul_a = sum_x; mul_b = sum_y;     end
      OP_SCALE: begin mul_a = tmp;   mul_b = FIT_SCALE; end
      OP_ASX:   begin mul_a = slope; mul_b = sum_x;     end
      OP_SY1K:  begin mul_a = sum_y; mul_b = FIT_SCALE; end
      default:  mul_en = 1'b0;
    endcase
    mul_lo = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_from_index <= 1'b0;
    end else if (cfg_valid) begin
      x_from_index <= cfg_data;
    end
  end

  // sums and count, cleared once a result is handed to the output register
  always_ff @(posedge clk) begin
    if (rst || op == OP_OUT) begin
      sum_x      <= '0;
      sum_y      <= '0;
      sum_xx     <= '0;
      sum_xy     <= '0;
      count      <= '0;
      overflowed <= 1'b0;
    end else begin
      case (op)
        OP_MXY: if (keep) sum_xx <= sum_xx + prod;
        OP_ACC: begin
          if (keep) begin
            sum_xy <= sum_xy + prod;
            sum_x  <= sum_x + x_reg;
            sum_y  <= sum_y + y_reg;
            count  <= count + 1'b1;
          end else begin
            overflowed <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        x_reg    <= x_from_index ? n32 : $unsigned(x_value);
        y_reg    <= $unsigned(y_value);
        last_reg <= last_point;
        keep     <= count < CW'(MAX_POINTS);
      end
      OP_SXSX: tmp   <= prod;
      OP_NSXY: den   <= tmp - prod;
      OP_SXSY: tmp   <= prod;
      OP_NUM:  tmp   <= tmp - prod;
      OP_SLOPE: slope <= div_q;
      OP_SY1K: tmp   <= prod;
      OP_ICN:  tmp   <= prod - tmp;
      OP_ICPT: icpt  <= div_q;
      default: ;
    endcase
  end

  assign div_start = (op == OP_DIVS) || (op == OP_DIVI);
  assign div_num   = (op == OP_DIVS) ? prod : tmp;
  assign div_den   = (op == OP_DIVS) ? den : n32;

  llsf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // den is only looked at when the fit got as far as computing it
  always_comb begin
    if (overflowed) begin
      status_next = FIT_TOO_MANY;
    end else if (count < CW'(2)) begin
      status_next = FIT_TOO_FEW;
    end else if (den == '0) begin
      status_next = FIT_DEN_ZERO;
    end else begin
      status_next = FIT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_OUT) begin
      slope_scaled     <= (status_next == FIT_OK) ? $signed(slope) : '0;
      intercept_scaled <= (status_next == FIT_OK) ? $signed(icpt) : '0;
      fit_status       <= status_next;
      points_used      <= 7'(count);
    end
  end

  always_comb begin
    status.is_last    = last_reg;
    status.overflowed = overflowed;
    status.too_few    = count < CW'(2);
    status.den_zero   = den == '0;
    status.div_busy   = div_busy;
    status.out_free   = !out_valid || out_ready;
  end

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> count == CW'(MAX_POINTS))
    else $error("count overflow flagged before the point limit");

endmodule

@@ src/linear_least_squares_fit_unit.sv @@
// Streaming least-squares line fit. Points (x, y) are taken one at a time and
// folded into wrapping 32-bit sums of x, y, x*x and x*y through one shared
// 32x32 multiplier, so a new point is taken only once the last one is folded in.
// On the item marked last_point the unit forms slope*1000 and intercept*1000
// with two passes of a one-bit-per-cycle divider; the fit goes straight to the
// output step when the status is set early by too many or too few points or by
// a zero denominator, and it waits for the output register to free.
// The result sits in an output register, so the next point set may start while
// it waits. x_from_index set to 1 uses the point's index within the set as x.
// Points beyond MAX_POINTS are dropped.
// depends on llsf_pkg, llsf_ctrl, llsf_dp

module linear_least_squares_fit_unit import llsf_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] y_value,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] slope_scaled,
  output logic signed [31:0] intercept_scaled,
  output logic [1:0]         fit_status,
  output logic [6:0]         points_used
);

  dp_op_t     op;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  llsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .op       (op)
  );

  llsf_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .op               (op),
    .status           (status),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .x_value          (x_value),
    .y_value          (y_value),
    .last_point       (last_point),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .slope_scaled     (slope_scaled),
    .intercept_scaled (intercept_scaled),
    .fit_status       (fit_status),
    .points_used      (points_used)
  );

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for linear_least_squares_fit_unit: feeds point sets, predicts
// slope, intercept, status and point count, and compares every fit result
// depends on llsf_pkg and the linear_least_squares_fit_unit rtl
`timescale 1ns / 1ps

module tb_top;
  import llsf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_PRINTS = 200;

  typedef struct {
    logic [31:0] slope;
    logic [31:0] icpt;
    fit_status_t status;
    logic [6:0]  used;
  } line_fit_t;

  // signed 32-bit quotient, truncated toward zero, most negative / -1 wraps
  function automatic logic [31:0] div_toward_zero(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  class line_fit_tracker;
    bit          index_mode;
    logic [31:0] sum_x, sum_y, sum_xx, sum_xy;
    int unsigned n_points;
    bit          dropped;
    line_fit_t   pending_fits[$];
    int unsigned errors;

    function new();
      index_mode = 1'b0;
      errors = 0;
      clear();
    endfunction

    function void clear();
      sum_x = '0;
      sum_y = '0;
      sum_xx = '0;
      sum_xy = '0;
      n_points = 0;
      dropped = 1'b0;
    endfunction

    function void set_mode(bit m);
      index_mode = m;
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void fold_point(logic [31:0] xv, logic [31:0] yv, bit lastp);
      logic [31:0] x, n, den, num;
      line_fit_t r;
      if (n_points < MAX_POINTS_DEF) begin
        x = index_mode ? n_points : xv;
        sum_x += x;
        sum_y += yv;
        sum_xx += x * x;
        sum_xy += x * yv;
        n_points++;
      end else begin
        dropped = 1'b1;
      end
      if (!lastp) return;
      r.slope = '0;
      r.icpt = '0;
      r.status = FIT_OK;
      r.used = n_points[6:0];
      n = n_points;
      if (dropped) begin
        r.status = FIT_TOO_MANY;
      end else if (n_points < 2) begin
        r.status = FIT_TOO_FEW;
      end else begin
        den = n * sum_xx - sum_x * sum_x;
        if (den == 0) begin
          r.status = FIT_DEN_ZERO;
        end else begin
          num = (n * sum_xy - sum_x * sum_y) * FIT_SCALE;
          r.slope = div_toward_zero(num, den);
          r.icpt = div_toward_zero(sum_y * FIT_SCALE - r.slope * sum_x, n);
        end
      end
      pending_fits.push_back(r);
      clear();
    endfunction

    task check_fit(logic [31:0] slope, logic [31:0] icpt, logic [1:0] status,
                   logic [6:0] used);
      line_fit_t e;
      if (pending_fits.size() == 0) begin
        report("fit result with no point set pending");
        return;
      end
      e = pending_fits.pop_front();
      if (slope !== e.slope)
        report($sformatf("slope_scaled %0d, expected %0d", $signed(slope), $signed(e.slope)));
      if (icpt !== e.icpt)
        report($sformatf("intercept_scaled %0d, expected %0d", $signed(icpt),
                         $signed(e.icpt)));
      if (status !== e.status)
        report($sformatf("fit_status %0d, expected %0d", status, e.status));
      if (used !== e.used)
        report($sformatf("points_used %0d, expected %0d", used, e.used));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic               last_point;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] slope_scaled;
  logic signed [31:0] intercept_scaled;
  logic [1:0]         fit_status;
  logic [6:0]         points_used;

  int unsigned     cycle = 0;
  line_fit_tracker fits = new();

  linear_least_squares_fit_unit dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .x_value          (x_value),
    .y_value          (y_value),
    .last_point       (last_point),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .slope_scaled     (slope_scaled),
    .intercept_scaled (intercept_scaled),
    .fit_status       (fit_status),
    .points_used      (points_used)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // no idling on either side inside this window
  function automatic bit quiet_window();
    return cycle >= 8000 && cycle < 14000;
  endfunction

  function automatic bit side_idles();
    return !quiet_window() && $urandom_range(0, 99) < 19;
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 2000) - 1000;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  // x for an 8-point set whose denominator wraps to -1: solve 7b^2 - b + 2 = 0
  // mod 2^30 bit by bit, then x = 2b
  function automatic logic [31:0] wrap_den_abscissa();
    logic [31:0] b, f;
    b = '0;
    for (int k = 1; k < 30; k++) begin
      f = 7 * b * b - b + 2;
      if (f[k]) b[k] = 1'b1;
    end
    return b << 1;
  endfunction

  task automatic send_point(logic [31:0] xv, logic [31:0] yv, bit lastp);
    while (side_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_value <= xv;
    y_value <= yv;
    last_point <= lastp;
    do @(posedge clk); while (!in_ready);
    fits.fold_point(xv, yv, lastp);
  endtask

  task automatic send_set(int unsigned size);
    logic [31:0] x_common;
    bit          same_x;
    same_x = $urandom_range(0, 9) == 0;
    x_common = pick_coord();
    for (int unsigned i = 0; i < size; i++)
      send_point(same_x ? x_common : pick_coord(), pick_coord(), i == size - 1);
  endtask

  // drops the input so the item just taken is not offered again
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (fits.pending_fits.size() != 0) @(posedge clk);
    // trailing points of a set may still be in the accumulator
    repeat (50) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fits.set_mode(m);
  endtask

  initial begin : stimulus
    logic [31:0] a;
    int unsigned sent, size, pick;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= 1'b0;
    in_valid <= 1'b0;
    x_value <= '0;
    y_value <= '0;
    last_point <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single point, extreme values
    send_point(32'h7fff_ffff, 32'h8000_0000, 1'b1);
    // equal abscissae
    send_point(5, 7, 1'b0);
    send_point(5, -9, 1'b1);
    // plain line through two points
    send_point(0, 0, 1'b0);
    send_point(1, 1000, 1'b1);
    // opposite extremes
    send_point(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 1'b1);
    // distinct x whose denominator wraps to zero
    send_point(0, 3, 1'b0);
    send_point(32'h0001_0000, 4, 1'b1);
    // slope quotient of most negative by -1
    a = wrap_den_abscissa();
    send_point(a, 0, 1'b0);
    send_point(1, 0, 1'b0);
    send_point(0, 32'h1000_0000, 1'b0);
    for (int i = 0; i < 5; i++) send_point(0, 0, i == 4);

    for (int ph = 0; ph < 6; ph++) begin
      wait_until_idle();
      write_mode(ph % 2 == 0);
      sent = 0;
      while (sent < 190) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) size = $urandom_range(62, 70);
        else if (pick < 10) size = 1;
        else size = $urandom_range(2, 9);
        send_set(size);
        sent += size;
      end
    end

    wait_until_idle();
    repeat (100) @(posedge clk);
    if (fits.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin : result_sink
    int unsigned results_seen, hold_left;
    bit          held_once;
    results_seen = 0;
    hold_left = 0;
    held_once = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        fits.check_fit(slope_scaled, intercept_scaled, fit_status, points_used);
        results_seen++;
      end
      // one long hold-off while points keep coming, so the unit backs up
      if (!held_once && results_seen >= 60 && in_valid) begin
        held_once = 1'b1;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !side_idles();
      end
    end
  end

endmodule
